// File: hdl/frp_pkg.sv
// shared types, character codes and helpers for the fasta record parser
package frp_pkg;

    localparam int unsigned PosW  = 64;
    localparam int unsigned ByteW = 8;
    localparam int unsigned KindW = 3;
    localparam int unsigned SlotN = 3;

    localparam logic [ByteW-1:0] ChGt    = 8'h3E;
    localparam logic [ByteW-1:0] ChColon = 8'h3A;
    localparam logic [ByteW-1:0] ChSub   = 8'h1A;
    localparam logic [ByteW-1:0] ChLf    = 8'h0A;
    localparam logic [ByteW-1:0] ChCr    = 8'h0D;
    localparam logic [ByteW-1:0] ChZero  = 8'h30;
    localparam logic [ByteW-1:0] ChNine  = 8'h39;
    localparam logic [ByteW-1:0] ChSpace = 8'h20;
    localparam logic [ByteW-1:0] ChTab   = 8'h09;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_HEADER = 3'd1,
        PH_BREAKS = 3'd2,
        PH_SEQ    = 3'd3,
        PH_STOP   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        HF_BLANKS = 2'd0,
        HF_NAME   = 2'd1,
        HF_COLON  = 2'd2,
        HF_DIGITS = 2'd3
    } t_hfield;

    typedef enum logic [KindW-1:0] {
        K_SEQ    = 3'd0,
        K_NAME   = 3'd1,
        K_HDR    = 3'd2,
        K_END    = 3'd3,
        K_NOMORE = 3'd4
    } t_kind;

    typedef struct packed {
        t_phase           phase;
        logic             prev_was_break;
        logic [PosW-1:0]  position_acc;
        t_hfield          header_field;
        logic             digits_open;
    } t_state;

    typedef struct packed {
        t_kind            kind;
        logic [ByteW-1:0] out_byte;
        logic [PosW-1:0]  start_position;
    } t_result;

    // state at the start of a record, and after reset with phase forced to start
    function automatic t_state open_record();
        t_state s;
        s.phase          = PH_HEADER;
        s.prev_was_break = 1'b0;
        s.position_acc   = {{(PosW-1){1'b0}}, 1'b1};
        s.header_field   = HF_BLANKS;
        s.digits_open    = 1'b0;
        return s;
    endfunction

    function automatic t_result mk_res(t_kind k, logic [ByteW-1:0] b, logic [PosW-1:0] p);
        t_result r;
        r.kind           = k;
        r.out_byte       = b;
        r.start_position = p;
        return r;
    endfunction

endpackage

// File: hdl/frp_step.sv
// next-state and result logic for one input byte
module frp_step
    import frp_pkg::*;
(
    input  t_state                 i_state,
    input  logic [ByteW-1:0]       i_byte,
    input  logic                   i_last,
    output t_state                 o_state,
    output t_result [SlotN-1:0]    o_res,
    output logic [1:0]             o_cnt
);

    logic             is_brk;
    logic             is_dig;
    logic [3:0]       dig;
    logic             seq_pwb;
    logic             run_seq;
    logic [PosW-1:0]  acc_x10;

    assign is_brk  = (i_byte == ChLf) || (i_byte == ChCr);
    assign is_dig  = (i_byte >= ChZero) && (i_byte <= ChNine);
    assign dig     = 4'(i_byte - ChZero);
    assign acc_x10 = {i_state.position_acc[PosW-4:0], 3'b000}
                   + {i_state.position_acc[PosW-2:0], 1'b0};

    always_comb begin
        o_state = i_state;
        o_res   = '0;
        o_cnt   = 2'd0;
        seq_pwb = i_state.prev_was_break;
        run_seq = 1'b0;

        case (i_state.phase)
            PH_START: begin
                if (i_byte == ChGt) begin
                    o_state = open_record();
                    if (i_last) begin
                        o_res[o_cnt]  = mk_res(K_NOMORE, '0, '0);
                        o_cnt         = o_cnt + 2'd1;
                        o_state.phase = PH_STOP;
                    end
                end else begin
                    o_res[o_cnt]  = mk_res(K_NOMORE, '0, '0);
                    o_cnt         = o_cnt + 2'd1;
                    o_state.phase = PH_STOP;
                end
            end
            PH_HEADER: begin
                if (i_byte == ChSub || i_last) begin
                    o_res[o_cnt]  = mk_res(K_NOMORE, '0, '0);
                    o_cnt         = o_cnt + 2'd1;
                    o_state.phase = PH_STOP;
                end else if (is_brk) begin
                    o_state.phase = PH_BREAKS;
                end else begin
                    case (i_state.header_field)
                        HF_BLANKS, HF_NAME: begin
                            if (i_state.header_field == HF_BLANKS
                                && (i_byte == ChSpace || i_byte == ChTab)) begin
                                o_state.header_field = HF_BLANKS;
                            end else if (i_byte == ChColon) begin
                                o_state.header_field = HF_COLON;
                            end else begin
                                o_state.header_field = HF_NAME;
                                o_res[o_cnt] = mk_res(K_NAME, i_byte, '0);
                                o_cnt        = o_cnt + 2'd1;
                            end
                        end
                        HF_COLON: begin
                            o_state.header_field = HF_DIGITS;
                            o_state.position_acc = is_dig ? {{(PosW-4){1'b0}}, dig} : '0;
                            o_state.digits_open  = is_dig;
                        end
                        default: begin
                            if (i_state.digits_open && is_dig) begin
                                o_state.position_acc = acc_x10 + {{(PosW-4){1'b0}}, dig};
                            end else begin
                                o_state.digits_open = 1'b0;
                            end
                        end
                    endcase
                end
            end
            PH_BREAKS: begin
                if ((is_brk && i_last) || (!is_brk && i_byte == ChSub)) begin
                    o_res[o_cnt]  = mk_res(K_NOMORE, '0, '0);
                    o_cnt         = o_cnt + 2'd1;
                    o_state.phase = PH_STOP;
                end else if (!is_brk) begin
                    o_res[o_cnt] = mk_res(K_HDR, '0, i_state.position_acc - 64'd1);
                    o_cnt        = o_cnt + 2'd1;
                    seq_pwb      = 1'b1;
                    run_seq      = 1'b1;
                end
            end
            PH_SEQ: begin
                run_seq = 1'b1;
            end
            PH_STOP: begin
                o_state.phase = PH_STOP;
            end
            default: begin
                o_state.phase = PH_STOP;
            end
        endcase

        if (run_seq) begin
            if (i_byte == ChGt && seq_pwb) begin
                o_res[o_cnt] = mk_res(K_END, '0, '0);
                o_cnt        = o_cnt + 2'd1;
                o_state      = open_record();
                if (i_last) begin
                    o_res[o_cnt]  = mk_res(K_NOMORE, '0, '0);
                    o_cnt         = o_cnt + 2'd1;
                    o_state.phase = PH_STOP;
                end
            end else begin
                if (!is_brk && i_byte != ChSub) begin
                    o_res[o_cnt] = mk_res(K_SEQ, i_byte, '0);
                    o_cnt        = o_cnt + 2'd1;
                end
                o_state.phase          = PH_SEQ;
                o_state.prev_was_break = is_brk;
                if (i_last) begin
                    o_res[o_cnt]  = mk_res(K_END, '0, '0);
                    o_cnt         = o_cnt + 2'd1;
                    o_state       = open_record();
                    o_state.phase = PH_START;
                end
            end
        end
    end

endmodule

// File: hdl/frp_outq.sv
// result buffer: holds the up to three results of one byte and sends them one by one
module frp_outq
    import frp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  t_result [SlotN-1:0]  i_res,
    input  logic [1:0]           i_cnt,
    output logic                 o_free,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_result              o_res,
    output logic                 o_last
);

    t_result [SlotN-1:0] r_slot;
    logic [1:0]          r_idx;
    logic [1:0]          r_left;
    logic                out_acc;

    assign o_valid = (r_left != 2'd0);
    assign out_acc = o_valid && i_ready;
    assign o_free  = (r_left == 2'd0) || ((r_left == 2'd1) && i_ready);
    assign o_res   = r_slot[r_idx];
    assign o_last  = (r_left == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= 2'd0;
            r_left <= 2'd0;
        end else if (i_load) begin
            r_slot <= i_res;
            r_idx  <= 2'd0;
            r_left <= i_cnt;
        end else if (out_acc) begin
            r_idx  <= r_idx + 2'd1;
            r_left <= r_left - 2'd1;
        end
    end

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_idx} + {1'b0, r_left}) <= 3'd3)
        else $error("result index runs past the stored results");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (o_free && i_cnt != 2'd0))
        else $error("results loaded over pending results");

endmodule

// File: hdl/fasta_record_parser.sv
// top level of the fasta record parser
//
// usage:
//   s_axis carries the fasta text, one byte per transaction; s_axis_tlast marks
//   the last byte of the file. m_axis carries the results: m_axis_tuser holds the
//   kind (sequence byte, name byte, header done, record end, no more entries),
//   m_axis_tdata the byte and the start position minus one, m_axis_tlast flags
//   the final result caused by one input byte.
//   a byte waits in the input register, and its results are registered in the
//   result buffer, which drives m_axis_tvalid.
//   throughput: one byte per cycle while each byte gives at most one result and
//   m_axis_tready is high; a byte with several results holds the result buffer
//   until all are sent, as it sends one result per cycle while m_axis_tready
//   is high. bytes that give no result pass without waiting on the output.
//   after a bad record start, a cut-short header or a record mark as the last
//   byte the block reports no more entries and then swallows all bytes until
//   reset. a clean end of file returns it to its reset state.
//   reset (synchronous, active low) clears the parse state and empties both
//   the input register and the result buffer.
//   when m_axis_tready is low the pending results hold; the input register
//   keeps taking bytes until one that gives a result waits in it, then
//   s_axis_tready falls.
module fasta_record_parser
    import frp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,   // [7:0] out_byte, [71:8] start_position
    output logic [2:0]   m_axis_tuser,   // [2:0] kind
    output logic         m_axis_tlast
);

    logic                r_in_valid;
    logic [ByteW-1:0]    r_in_byte;
    logic                r_in_last;
    t_state              r_state;
    t_state              n_state;
    t_result [SlotN-1:0] step_res;
    logic [1:0]          step_cnt;
    logic                q_free;
    logic                advance;
    logic                load;
    t_result             q_res;

    t_state              rst_state;

    always_comb begin
        rst_state       = open_record();
        rst_state.phase = PH_START;
    end

    frp_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_state (n_state),
        .o_res   (step_res),
        .o_cnt   (step_cnt)
    );

    // a byte with no result never needs the buffer
    assign advance       = r_in_valid && (q_free || step_cnt == 2'd0);
    assign load          = advance && (step_cnt != 2'd0);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= rst_state;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    frp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_res   (step_res),
        .i_cnt   (step_cnt),
        .o_free  (q_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (q_res),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {q_res.start_position, q_res.out_byte};
    assign m_axis_tuser = q_res.kind;

    a_stop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_state.phase == PH_STOP) |-> (step_cnt == 2'd0))
        else $error("stopped parser produced a result");

    a_nomore_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == K_NOMORE) |-> m_axis_tlast)
        else $error("no-more-entries is not the final result of its byte");

    a_hdr_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == K_HDR) |-> !m_axis_tlast)
        else $error("header done without a following result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

// File: test/fasta_record_parser_tb.sv
`timescale 1ns / 1ps
// self-checking stream testbench for the fasta record parser
module fasta_record_parser_tb;
    import frp_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       eod;
        logic       quiet;
        logic       drain;
    } t_text_item;

    typedef struct {
        t_kind       kind;
        logic [7:0]  out_byte;
        logic [63:0] start_pos;
        logic        last;
    } t_parse_res;

    localparam int unsigned DirectedN = 24;
    localparam int unsigned RandomN   = 220;
    localparam int unsigned CalmTailN = 40;
    localparam logic [7:0]  Bases [4] = '{8'h41, 8'h43, 8'h47, 8'h54};

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [7:0] data_byte
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;          // [7:0] out_byte, [71:8] start_position
    logic [2:0]  m_axis_tuser;          // [2:0] kind
    logic        m_axis_tlast;

    t_text_item text_q[$];
    t_text_item nxt;
    t_parse_res parsed_q[$];
    t_parse_res step_res[$];
    t_parse_res want;

    // parser state as predicted
    t_phase      ph;
    logic        after_break;
    logic [63:0] pos_acc;
    t_hfield     hfield;
    logic        digits_live;

    logic  gen_quiet  = 1'b0;
    logic  gen_drain  = 1'b0;
    logic  text_taken = 1'b0;
    logic  calm       = 1'b0;
    int    src_gap = 0, sink_gap = 0;
    int    errors = 0, bytes_in = 0, results_seen = 0, records_closed = 0, drains = 0;
    int    wait_cnt;
    string stop_case;

    fasta_record_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic is_brk(logic [7:0] c);
        return c == ChLf || c == ChCr;
    endfunction

    function automatic logic is_dig(logic [7:0] c);
        return c >= ChZero && c <= ChNine;
    endfunction

    function void emit(t_kind k, logic [7:0] b, logic [63:0] p);
        step_res.push_back('{kind: k, out_byte: b, start_pos: p, last: 1'b0});
    endfunction

    function void halt();
        emit(K_NOMORE, 8'h00, 64'd0);
        ph = PH_STOP;
    endfunction

    function void begin_record();
        ph          = PH_HEADER;
        after_break = 1'b0;
        pos_acc     = 64'd1;
        hfield      = HF_BLANKS;
        digits_live = 1'b0;
    endfunction

    function void header_char(logic [7:0] c);
        logic [63:0] dval;
        dval = {56'd0, c - ChZero};
        if (hfield == HF_BLANKS) begin
            if (c == ChSpace || c == ChTab) return;
            hfield = HF_NAME;
        end
        if (hfield == HF_NAME) begin
            if (c == ChColon) hfield = HF_COLON;
            else emit(K_NAME, c, 64'd0);
            return;
        end
        if (hfield == HF_COLON) begin
            hfield      = HF_DIGITS;
            pos_acc     = 64'd0;
            digits_live = 1'b0;
            if (is_dig(c)) begin
                pos_acc     = dval;
                digits_live = 1'b1;
            end
            return;
        end
        if (digits_live && is_dig(c)) pos_acc = pos_acc * 64'd10 + dval;
        else digits_live = 1'b0;
    endfunction

    function void seq_char(logic [7:0] c, logic eod);
        if (c == ChGt && after_break) begin
            emit(K_END, 8'h00, 64'd0);
            begin_record();
            if (eod) halt();
            return;
        end
        if (!is_brk(c) && c != ChSub) emit(K_SEQ, c, 64'd0);
        after_break = is_brk(c);
        if (eod) begin
            // clean end of file: back to the state after reset
            emit(K_END, 8'h00, 64'd0);
            begin_record();
            ph = PH_START;
        end
    endfunction

    function void parse_byte(logic [7:0] c, logic eod);
        step_res.delete();
        case (ph)
            PH_START: begin
                if (c == ChGt) begin
                    begin_record();
                    if (eod) halt();
                end else begin
                    halt();
                end
            end
            PH_HEADER: begin
                if (c == ChSub || eod) halt();
                else if (is_brk(c)) ph = PH_BREAKS;
                else header_char(c);
            end
            PH_BREAKS: begin
                if (is_brk(c)) begin
                    if (eod) halt();
                end else if (c == ChSub) begin
                    halt();
                end else begin
                    emit(K_HDR, 8'h00, pos_acc - 64'd1);
                    ph          = PH_SEQ;
                    after_break = 1'b1;
                    seq_char(c, eod);
                end
            end
            PH_SEQ: seq_char(c, eod);
            default: ph = PH_STOP;
        endcase
        if (step_res.size() != 0) step_res[step_res.size() - 1].last = 1'b1;
        foreach (step_res[i]) parsed_q.push_back(step_res[i]);
    endfunction

    task automatic put_byte(logic [7:0] b, logic eod);
        text_q.push_back('{data: b, eod: eod, quiet: gen_quiet, drain: gen_drain});
        gen_drain = 1'b0;
    endtask

    // any byte that keeps a header line going
    function automatic logic [7:0] any_hdr_byte(logic no_colon);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (is_brk(b) || b == ChSub || (no_colon && b == ChColon));
        return b;
    endfunction

    task automatic put_digits(int n);
        repeat (n) put_byte(ChZero + 8'($urandom_range(0, 9)), 1'b0);
    endtask

    task automatic put_hdr_tail();
        repeat ($urandom_range(1, 4)) put_byte(any_hdr_byte(1'b0), 1'b0);
    endtask

    task automatic put_name();
        repeat ($urandom_range(1, 3)) put_byte(any_hdr_byte(1'b1), 1'b0);
    endtask

    task automatic gen_sequence(int len, logic is_last);
        logic [7:0] b;
        logic       prev_brk;
        int         r;
        prev_brk = 1'b1;
        for (int i = 0; i < len; i++) begin
            // the first byte confirms the record; '>' after a break would close it
            do begin
                r = $urandom_range(0, 9);
                if (r < 5) b = Bases[$urandom_range(0, 3)];
                else if (r < 7) b = $urandom_range(0, 1) ? ChCr : ChLf;
                else if (r == 7) b = ChSub;
                else b = 8'($urandom_range(0, 255));
            end while ((i == 0 && (is_brk(b) || b == ChSub)) || (prev_brk && b == ChGt));
            put_byte(b, is_last && i == len - 1);
            prev_brk = is_brk(b);
        end
        if (!is_last && len > 0 && !prev_brk) put_byte($urandom_range(0, 1) ? ChCr : ChLf, 1'b0);
    endtask

    task automatic gen_record(logic is_last);
        logic [7:0] b;
        int         slen;
        put_byte(ChGt, 1'b0);
        repeat ($urandom_range(0, 3)) put_byte($urandom_range(0, 1) ? ChSpace : ChTab, 1'b0);
        repeat ($urandom_range(0, 6)) put_byte(any_hdr_byte(1'b1), 1'b0);
        case ($urandom_range(0, 5))
            0: ;
            1: begin
                put_byte(ChColon, 1'b0);
                put_digits($urandom_range(1, 3));
            end
            2: begin
                // long digit runs can wrap the position
                put_byte(ChColon, 1'b0);
                put_digits($urandom_range(17, 22));
            end
            3: begin
                put_byte(ChColon, 1'b0);
                do b = any_hdr_byte(1'b0);
                while (is_dig(b));
                put_byte(b, 1'b0);
                put_hdr_tail();
            end
            4: begin
                put_byte(ChColon, 1'b0);
                put_digits($urandom_range(1, 4));
                put_hdr_tail();
            end
            default: put_byte(ChColon, 1'b0);
        endcase
        repeat ($urandom_range(1, 3)) put_byte($urandom_range(0, 1) ? ChCr : ChLf, 1'b0);
        slen = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
        if (is_last && slen == 0) slen = 1;
        gen_sequence(slen, is_last);
    endtask

    task automatic gen_file(int idx);
        int nrec;
        nrec      = $urandom_range(1, 4);
        gen_quiet = (text_q.size() > DirectedN + RandomN - CalmTailN) || ($urandom_range(0, 3) == 0);
        gen_drain = (idx % 6 == 0);
        for (int r = 0; r < nrec; r++) gen_record(r == nrec - 1);
    endtask

    // the block only recovers by reset, so one stopping case closes the run
    task automatic gen_stop_tail();
        logic [7:0] b;
        gen_quiet = 1'b1;
        case ($urandom_range(0, 5))
            0: begin
                stop_case = "a bad record start";
                do b = 8'($urandom_range(0, 255));
                while (b == ChGt);
                put_byte(b, 1'b0);
            end
            1: begin
                stop_case = "a lone record mark at end of data";
                put_byte(ChGt, 1'b1);
            end
            2: begin
                stop_case = "a header cut by byte 26";
                put_byte(ChGt, 1'b0);
                put_name();
                put_byte(ChSub, 1'b0);
            end
            3: begin
                stop_case = "a header cut by end of data";
                put_byte(ChGt, 1'b0);
                put_name();
                put_byte(any_hdr_byte(1'b1), 1'b1);
            end
            4: begin
                stop_case = "header line breaks cut by byte 26";
                put_byte(ChGt, 1'b0);
                put_name();
                put_byte(ChLf, 1'b0);
                put_byte(ChSub, 1'b0);
            end
            default: begin
                stop_case = "header line breaks cut by end of data";
                put_byte(ChGt, 1'b0);
                put_name();
                put_byte(ChLf, 1'b0);
                put_byte(ChCr, 1'b1);
            end
        endcase
        repeat (4) put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // source and sink, both driven on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || text_taken) begin
                text_taken = 1'b0;
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (text_q.size() != 0 && !(text_q[0].drain && parsed_q.size() != 0)) begin
                    nxt = text_q.pop_front();
                    if (nxt.drain) drains++;
                    calm = nxt.quiet;
                    s_axis_tdata  <= nxt.data;
                    s_axis_tlast  <= nxt.eod;
                    s_axis_tvalid <= 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 16);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            if (calm) begin
                sink_gap = 0;
                m_axis_tready <= 1'b1;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 16);
            end
        end
    end

    // predict on each text transaction, check each result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready === 1'b1) begin
            parse_byte(s_axis_tdata, s_axis_tlast);
            bytes_in++;
            text_taken = 1'b1;
        end
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            results_seen++;
            if (parsed_q.size() == 0) begin
                errors++;
                $display("%0t ns: result kind %0d with nothing due", $time, m_axis_tuser);
            end else begin
                want = parsed_q.pop_front();
                if (want.kind == K_END) records_closed++;
                if (m_axis_tuser !== want.kind) begin
                    errors++;
                    $display("%0t ns: kind expected %0d, got %0d", $time, want.kind, m_axis_tuser);
                end
                if (m_axis_tdata[7:0] !== want.out_byte) begin
                    errors++;
                    $display("%0t ns: byte expected %h, got %h", $time, want.out_byte,
                             m_axis_tdata[7:0]);
                end
                if (m_axis_tdata[71:8] !== want.start_pos) begin
                    errors++;
                    $display("%0t ns: position expected %h, got %h", $time, want.start_pos,
                             m_axis_tdata[71:8]);
                end
                if (m_axis_tlast !== want.last) begin
                    errors++;
                    $display("%0t ns: last expected %b, got %b", $time, want.last, m_axis_tlast);
                end
            end
        end
    end

    initial begin
        begin_record();
        ph        = PH_START;
        stop_case = "none";

        // blanks, name byte extremes, digits then ignored bytes, 26 in the sequence
        put_byte(ChGt, 1'b0);    put_byte(ChSpace, 1'b0); put_byte(ChTab, 1'b0);
        put_byte(8'h00, 1'b0);   put_byte(8'hFF, 1'b0);   put_byte(ChColon, 1'b0);
        put_byte("4", 1'b0);     put_byte("2", 1'b0);     put_byte("x", 1'b0);
        put_byte("9", 1'b0);     put_byte(ChCr, 1'b0);    put_byte(ChLf, 1'b0);
        put_byte(8'hFF, 1'b0);   put_byte(ChSub, 1'b0);   put_byte(ChLf, 1'b0);
        put_byte(ChGt, 1'b0);
        // non-digit after the colon, then an empty sequence
        put_byte("N", 1'b0);     put_byte(ChColon, 1'b0); put_byte("Q", 1'b0);
        put_byte(ChLf, 1'b0);    put_byte(ChGt, 1'b0);
        // colon as the last header byte, clean end of data on a kept byte
        put_byte(ChColon, 1'b0); put_byte(ChCr, 1'b0);    put_byte(8'h00, 1'b1);

        for (int f = 0; text_q.size() < DirectedN + RandomN; f++) gen_file(f);
        gen_stop_tail();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (text_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        for (wait_cnt = 0; parsed_q.size() != 0 && wait_cnt < 5000; wait_cnt++)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (parsed_q.size() != 0) begin
            errors++;
            $display("%0t ns: %0d results still due at the end", $time, parsed_q.size());
        end

        $display("run: %0d bytes taken, %0d results checked, %0d records closed, %0d drain pauses",
                 bytes_in, results_seen, records_closed, drains);
        $display("run: stream closed by %s, then ignored bytes", stop_case);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("timeout with %0d results still due", parsed_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: fasta_record_parser.f
hdl/frp_pkg.sv
hdl/frp_step.sv
hdl/frp_outq.sv
hdl/fasta_record_parser.sv
test/fasta_record_parser_tb.sv
